// ----- rtl/ppmfd_pkg.sv -----
// ppmfd_pkg: shared types and constants for the PPM frame decoder.
// Used by ppmfd_gap_classify and ppm_frame_decoder_core; no dependencies.
`default_nettype none

package ppmfd_pkg;

    // Field widths
    localparam int US_W         = 16;
    localparam int TS_W         = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int MAX_CHANNELS = 8;
    localparam int CHAN_IDX_W   = 3;

    // Default channel count of a frame
    localparam int NUM_CHANNELS_DEF = 8;

    // Register values after reset
    localparam logic [US_W-1:0] SYNC_MIN_RST  = 16'd2200;
    localparam logic [US_W-1:0] PULSE_MIN_RST = 16'd950;
    localparam logic [US_W-1:0] PULSE_MAX_RST = 16'd2050;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_MIN  = 2'd0,
        REG_PULSE_MIN = 2'd1,
        REG_PULSE_MAX = 2'd2
    } t_cfg_reg;

    // Classification of one edge gap
    typedef struct packed {
        logic is_sync;
        logic in_window;
    } t_gap_class;

endpackage

`default_nettype wire

// ----- rtl/ppmfd_gap_classify.sv -----
// ppmfd_gap_classify: measures the gap between the current and the last PPM edge
// (low bits only, wrapping) and classifies it against the sync threshold and the pulse window.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_gap_classify (
    input  wire logic [ppmfd_pkg::US_W-1:0] i_now_lo,
    input  wire logic [ppmfd_pkg::US_W-1:0] i_last_lo,
    input  wire logic [ppmfd_pkg::US_W-1:0] i_sync_min_us,
    input  wire logic [ppmfd_pkg::US_W-1:0] i_pulse_min_us,
    input  wire logic [ppmfd_pkg::US_W-1:0] i_pulse_max_us,
    output logic      [ppmfd_pkg::US_W-1:0] o_gap_us,
    output ppmfd_pkg::t_gap_class           o_class
);

    // Take the gap modulo 65536: only the low bits of both times matter
    assign o_gap_us = i_now_lo - i_last_lo;

    // Compare against the sync threshold and the pulse window
    always_comb begin
        o_class.is_sync   = (o_gap_us >= i_sync_min_us);
        o_class.in_window = (o_gap_us >= i_pulse_min_us) && (o_gap_us <= i_pulse_max_us);
    end

endmodule

`default_nettype wire

// ----- rtl/ppm_frame_decoder_core.sv -----
// ppm_frame_decoder_core: PPM frame decoder; an input register, one pass of
// gap logic, and an output register that drives o_valid. Throughput is one
// item per cycle, held back only by i_ready.
// Synchronous active-low reset: decoder disarmed, channel count and last edge
// time cleared, registers back to 2200 / 950 / 2050 us, both stages empty.
// Depends on ppmfd_pkg and ppmfd_gap_classify.
`default_nettype none

module ppm_frame_decoder_core #(
    parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Edge items
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_on_ppm_pin,
    input  wire logic [ppmfd_pkg::TS_W-1:0]         i_timestamp_us,
    // Frame items
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan0_us,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan1_us,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan2_us,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan3_us,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan4_us,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan5_us,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan6_us,
    output logic      [ppmfd_pkg::US_W-1:0]         o_chan7_us,
    // Configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ppmfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ppmfd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int US_W  = ppmfd_pkg::US_W;
    localparam int TS_W  = ppmfd_pkg::TS_W;
    localparam int MAXC  = ppmfd_pkg::MAX_CHANNELS;
    localparam int IDX_W = ppmfd_pkg::CHAN_IDX_W;
    localparam logic [IDX_W:0] LP_NCH = (IDX_W+1)'(NUM_CHANNELS);

    // Configuration registers
    logic [US_W-1:0] r_sync_min, r_pulse_min, r_pulse_max;

    // Input stage
    logic            r_in_valid;
    logic            r_in_on_pin;
    logic [TS_W-1:0] r_in_ts;

    // Decoder state
    logic [TS_W-1:0]  r_last_edge;
    logic             r_armed;
    logic [IDX_W-1:0] r_chan_idx;
    logic [US_W-1:0]  r_store [MAXC];

    // Output stage
    logic            r_out_valid;
    logic [US_W-1:0] r_out_chan [MAXC];

    logic                  w_fire;
    logic [US_W-1:0]       w_gap;
    ppmfd_pkg::t_gap_class w_class;
    logic                  w_take_chan;
    logic                  w_last_chan;
    logic                  w_frame;
    logic [US_W-1:0]       n_out_chan [MAXC];

    // Configuration port: always ready, writes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_min  <= ppmfd_pkg::SYNC_MIN_RST;
            r_pulse_min <= ppmfd_pkg::PULSE_MIN_RST;
            r_pulse_max <= ppmfd_pkg::PULSE_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppmfd_pkg::REG_SYNC_MIN:  r_sync_min  <= i_cfg_data;
                ppmfd_pkg::REG_PULSE_MIN: r_pulse_min <= i_cfg_data;
                ppmfd_pkg::REG_PULSE_MAX: r_pulse_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the input stage whenever the decode stage moves on
    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_on_pin <= i_on_ppm_pin;
            r_in_ts     <= i_timestamp_us;
        end
    end

    // Gap measurement and classification
    ppmfd_gap_classify u_classify (
        .i_now_lo       (r_in_ts[US_W-1:0]),
        .i_last_lo      (r_last_edge[US_W-1:0]),
        .i_sync_min_us  (r_sync_min),
        .i_pulse_min_us (r_pulse_min),
        .i_pulse_max_us (r_pulse_max),
        .o_gap_us       (w_gap),
        .o_class        (w_class)
    );

    // Decide what this edge does
    assign w_take_chan = w_fire && r_in_on_pin && !w_class.is_sync && r_armed
                         && w_class.in_window;
    assign w_last_chan = (({1'b0, r_chan_idx} + (IDX_W+1)'(1)) >= LP_NCH);
    assign w_frame     = w_take_chan && w_last_chan;

    // Update the decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_armed     <= 1'b0;
            r_chan_idx  <= '0;
        end else if (w_fire && r_in_on_pin) begin
            r_last_edge <= r_in_ts;
            if (w_class.is_sync) begin
                r_armed    <= 1'b1;
                r_chan_idx <= '0;
            end else if (r_armed) begin
                if (w_class.in_window) begin
                    r_chan_idx <= w_last_chan ? '0 : r_chan_idx + IDX_W'(1);
                end else begin
                    r_armed <= 1'b0;
                end
            end
        end
    end

    // Store the accepted channel width
    always_ff @(posedge i_clk) begin
        if (w_take_chan) begin
            r_store[r_chan_idx] <= w_gap;
        end
    end

    // Assemble the frame, taking the current gap for the last channel
    always_comb begin
        for (int k = 0; k < MAXC; k++) begin
            if (k < NUM_CHANNELS) begin
                n_out_chan[k] = (r_chan_idx == IDX_W'(k)) ? w_gap : r_store[k];
            end else begin
                n_out_chan[k] = '0;
            end
        end
    end

    // Output register: hold the frame until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_frame) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame) begin
            r_out_chan <= n_out_chan;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_chan0_us = r_out_chan[0];
    assign o_chan1_us = r_out_chan[1];
    assign o_chan2_us = r_out_chan[2];
    assign o_chan3_us = r_out_chan[3];
    assign o_chan4_us = r_out_chan[4];
    assign o_chan5_us = r_out_chan[5];
    assign o_chan6_us = r_out_chan[6];
    assign o_chan7_us = r_out_chan[7];

    // Channel count never reaches the frame length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_chan_idx} < LP_NCH))
        else $error("channel count out of range");

    // A new frame only appears after a completing channel edge
    a_frame_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(w_frame))
        else $error("frame appeared without a completing edge");

    // A sync edge arms the decoder and restarts the count
    a_sync_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_on_pin && w_class.is_sync) |=> (r_armed && r_chan_idx == '0))
        else $error("sync edge did not arm the decoder");

    // A mid-frame channel advances the count by one
    a_chan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take_chan && !w_last_chan) |=> (r_chan_idx == $past(r_chan_idx) + IDX_W'(1)))
        else $error("channel count did not advance");

endmodule

`default_nettype wire

// ----- bench/tb_ppm_frame_decoder_core.sv -----
// tb_ppm_frame_decoder_core: self-checking bench for the PPM frame decoder core.
// Drives edge items and register writes, predicts frames in-line and checks them.
// Depends on ppmfd_pkg and ppm_frame_decoder_core.
`timescale 1ns / 100ps

module tb_ppm_frame_decoder_core;

    localparam int          CLK_HALF_NS   = 10;
    localparam int          FRAME_CHANS   = 8;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int unsigned RUN_LIMIT_NS  = 8_000_000;

    localparam int US_W       = ppmfd_pkg::US_W;
    localparam int TS_W       = ppmfd_pkg::TS_W;
    localparam int CFG_IDX_W  = ppmfd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ppmfd_pkg::CFG_DATA_W;
    localparam int CHAN_IDX_W = ppmfd_pkg::CHAN_IDX_W;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef logic [FRAME_CHANS-1:0][US_W-1:0] t_frame;
    typedef enum int {GAP_SYNC, GAP_PULSE, GAP_NOISE} t_gap_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_on_ppm_pin = 1'b0;
    logic [TS_W-1:0]       i_timestamp_us = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [US_W-1:0]       o_chan0_us, o_chan1_us, o_chan2_us, o_chan3_us;
    logic [US_W-1:0]       o_chan4_us, o_chan5_us, o_chan6_us, o_chan7_us;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Decoder state as predicted by the bench
    logic [US_W-1:0]       sync_min_us  = ppmfd_pkg::SYNC_MIN_RST;
    logic [US_W-1:0]       pulse_min_us = ppmfd_pkg::PULSE_MIN_RST;
    logic [US_W-1:0]       pulse_max_us = ppmfd_pkg::PULSE_MAX_RST;
    logic [TS_W-1:0]       last_edge_us = '0;
    logic                  armed = 1'b0;
    logic [CHAN_IDX_W-1:0] chan_idx = '0;
    t_frame                widths = '0;
    t_frame                frames_due[$];

    bit idle_on = 1'b1;
    int err_count = 0;
    int frames_checked = 0;
    int ppm_edges = 0;
    int foreign_edges = 0;
    int settings_used = 1;

    ppm_frame_decoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_on_ppm_pin   (i_on_ppm_pin),
        .i_timestamp_us (i_timestamp_us),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chan0_us     (o_chan0_us),
        .o_chan1_us     (o_chan1_us),
        .o_chan2_us     (o_chan2_us),
        .o_chan3_us     (o_chan3_us),
        .o_chan4_us     (o_chan4_us),
        .o_chan5_us     (o_chan5_us),
        .o_chan6_us     (o_chan6_us),
        .o_chan7_us     (o_chan7_us),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Free-running clock
    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Stall the frame side at random while idling is on
    always @(negedge i_clk) begin
        i_ready <= idle_on ? ($urandom_range(99) >= 22) : 1'b1;
    end

    // Advance the decoder prediction by one accepted edge item
    function automatic void decode_edge(input logic pin, input logic [TS_W-1:0] ts);
        logic [US_W-1:0] gap;
        if (!pin)
            return;
        gap = US_W'(ts - last_edge_us);
        last_edge_us = ts;
        // sync wins over the pulse window
        if (gap >= sync_min_us) begin
            armed = 1'b1;
            chan_idx = '0;
            return;
        end
        if (!armed)
            return;
        if (gap >= pulse_min_us && gap <= pulse_max_us) begin
            widths[chan_idx] = gap;
            if (chan_idx == CHAN_IDX_W'(FRAME_CHANS - 1)) begin
                chan_idx = '0;
                frames_due.push_back(widths);
            end else begin
                chan_idx = chan_idx + CHAN_IDX_W'(1);
            end
            return;
        end
        // out of both ranges: drop out until the next sync
        armed = 1'b0;
    endfunction

    // Choose a gap of the wanted kind for the current register setting
    function automatic logic [US_W-1:0] pick_gap(input t_gap_kind kind);
        int lo;
        int hi;
        case (kind)
            GAP_SYNC: return US_W'($urandom_range(65535, int'(sync_min_us)));
            GAP_PULSE: begin
                lo = int'(pulse_min_us);
                hi = int'(pulse_max_us);
                if (hi >= int'(sync_min_us))
                    hi = int'(sync_min_us) - 1;
                if (lo > hi)
                    return US_W'($urandom);
                case ($urandom_range(9))
                    0: return US_W'(lo);
                    1: return US_W'(hi);
                    default: return US_W'($urandom_range(hi, lo));
                endcase
            end
            default: return US_W'($urandom);
        endcase
    endfunction

    // Upper timestamp bits that leave the gap modulo 65536 unchanged
    function automatic logic [US_W-1:0] rand_hi();
        return ($urandom_range(3) == 0) ? US_W'($urandom) : '0;
    endfunction

    // Send one edge item; starts and ends at a falling edge
    task automatic send_edge(input logic pin, input logic [TS_W-1:0] ts);
        if (idle_on) begin
            while ($urandom_range(99) < 22) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid        <= 1'b1;
        i_on_ppm_pin   <= pin;
        i_timestamp_us <= ts;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_edge(pin, ts);
        if (pin)
            ppm_edges++;
        else
            foreign_edges++;
        @(negedge i_clk);
    endtask

    // Send a PPM edge a given gap after the last one
    task automatic send_ppm(input logic [US_W-1:0] gap, input logic [US_W-1:0] hi);
        send_edge(1'b1, last_edge_us + {16'h0, gap} + {hi, 16'h0});
    endtask

    // Hold the sender until every predicted frame has come out
    task automatic drain_frames();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (frames_due.size() != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register; starts and ends at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [US_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ppmfd_pkg::REG_SYNC_MIN:  sync_min_us  = val;
            ppmfd_pkg::REG_PULSE_MIN: pulse_min_us = val;
            ppmfd_pkg::REG_PULSE_MAX: pulse_max_us = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [US_W-1:0] sync_v, input logic [US_W-1:0] pmin_v,
                            input logic [US_W-1:0] pmax_v);
        drain_frames();
        write_reg(ppmfd_pkg::REG_SYNC_MIN, sync_v);
        write_reg(ppmfd_pkg::REG_PULSE_MIN, pmin_v);
        write_reg(ppmfd_pkg::REG_PULSE_MAX, pmax_v);
        settings_used++;
    endtask

    // One sync then eight channel slots, with occasional noise and breaks
    task automatic send_frame();
        int r;
        send_ppm(pick_gap(GAP_SYNC), rand_hi());
        for (int ch = 0; ch < FRAME_CHANS; ch++) begin
            r = $urandom_range(99);
            if (r < 4)
                send_edge(1'b0, $urandom);
            else if (r < 7)
                send_ppm(pick_gap(GAP_NOISE), rand_hi());
            else if (r < 9)
                drain_frames();
            send_ppm(pick_gap(GAP_PULSE), rand_hi());
        end
    endtask

    // Reset values, spare index, extremes, wraps, disarm and mid-frame sync
    task automatic test_default_regs();
        write_reg(REG_SPARE, 16'h0000);
        // first edge is measured from time zero, exactly at the sync threshold
        send_ppm(16'd2200, 16'h0);
        send_ppm(16'd950, 16'h0);
        send_ppm(16'd2050, 16'h0);
        send_edge(1'b0, $urandom);
        send_ppm(16'd1500, 16'h0);
        send_ppm(16'd1000, 16'h0001);
        send_ppm(16'd2000, 16'h0);
        send_ppm(16'd1234, 16'h0);
        send_ppm(16'd1777, 16'h0);
        send_ppm(16'd1100, 16'h0);
        drain_frames();
        // timestamp wraps both ways
        send_ppm(16'd3000, 16'hFFF0);
        send_ppm(16'd951, 16'h0010);
        send_ppm(16'd949, 16'h0);
        send_ppm(16'd1500, 16'h0);
        send_ppm(16'hFFFF, 16'h0);
        send_ppm(16'd1600, 16'h0);
        send_ppm(16'd1700, 16'h0);
        send_ppm(16'd2200, 16'h0);
        for (int ch = 0; ch < FRAME_CHANS; ch++)
            send_ppm(US_W'($urandom_range(2050, 950)), 16'h0);
    endtask

    // Sync threshold inside the window, then an empty window
    task automatic test_window_corners();
        set_regs(16'd1500, 16'd950, 16'd2050);
        send_ppm(16'd3000, 16'h0);
        send_ppm(16'd1800, 16'h0);
        for (int ch = 0; ch < FRAME_CHANS; ch++)
            send_ppm(US_W'($urandom_range(1499, 950)), 16'h0);
        set_regs(16'd2200, 16'd2000, 16'd1000);
        send_ppm(16'd3000, 16'h0);
        send_ppm(16'd1500, 16'h0);
        send_ppm(16'd1000, 16'h0);
        send_ppm(16'd2000, 16'h0);
    endtask

    task automatic test_random(input logic [US_W-1:0] sync_v, input logic [US_W-1:0] pmin_v,
                               input logic [US_W-1:0] pmax_v, input int n_edges,
                               input bit idle);
        int target;
        set_regs(sync_v, pmin_v, pmax_v);
        idle_on = idle;
        target = ppm_edges + n_edges;
        while (ppm_edges < target)
            send_frame();
    endtask

    // Compare each frame item with the oldest prediction
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        got = {o_chan7_us, o_chan6_us, o_chan5_us, o_chan4_us,
               o_chan3_us, o_chan2_us, o_chan1_us, o_chan0_us};
        if (i_rst_n && o_valid && i_ready) begin
            if (frames_due.size() == 0) begin
                $error("frame item with no prediction waiting");
                err_count++;
            end else begin
                want = frames_due.pop_front();
                frames_checked++;
                for (int k = 0; k < FRAME_CHANS; k++) begin
                    if (got[k] !== want[k]) begin
                        $error("chan%0d_us: expected %0d, got %0d", k, want[k], got[k]);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic [US_W-1:0] pmin_r;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_regs();
        test_window_corners();
        test_random(ppmfd_pkg::SYNC_MIN_RST, ppmfd_pkg::PULSE_MIN_RST,
                    ppmfd_pkg::PULSE_MAX_RST, 150, 1'b1);
        test_random(16'd3000, 16'd500, 16'd2999, 150, 1'b0);
        test_random(16'hFFFF, 16'h0000, 16'hFFFF, 150, 1'b1);
        test_random(16'h0000, 16'd950, 16'd2050, 40, 1'b1);
        test_random(16'd2200, 16'd2000, 16'd1000, 40, 1'b1);
        test_random(16'd1235, 16'd1234, 16'd1234, 120, 1'b1);
        repeat (3) begin
            pmin_r = US_W'($urandom_range(9000, 200));
            test_random(US_W'($urandom_range(20000, 10000)), pmin_r,
                        pmin_r + US_W'($urandom_range(3000, 1)), 100, 1'b1);
        end

        drain_frames();
        if (frames_due.size() != 0) begin
            $error("%0d predicted frames never came out", frames_due.size());
            err_count += frames_due.size();
        end
        $display("Sent %0d PPM edges and %0d foreign-pin edges over %0d register settings.",
                 ppm_edges, foreign_edges, settings_used);
        $display("Checked %0d frames; %0d mismatches.", frames_checked, err_count);
        if (err_count == 0)
            $display("[ppm_frame_decoder_core] OK");
        else
            $display("[ppm_frame_decoder_core] ERROR");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("[ppm_frame_decoder_core] ERROR");
        $finish;
    end

endmodule
